[design/tap_rate_meter_with_hysteresis_assert.svh]
// Assertion macros for the tap rate meter.
`ifndef TAP_RATE_METER_WITH_HYSTERESIS_ASSERT_SVH
`define TAP_RATE_METER_WITH_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TRM_ASSERT_NOW(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TRM_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

[design/trm_pkg.sv]
package trm_pkg;

  // Ring of recent taps
  localparam int HISTORY_DEPTH = 8;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  // Field widths
  localparam int STAMP_W = 32;
  localparam int MS_W    = 16;
  localparam int SPEED_W = 17;

  // Rate arithmetic: (count-1)*RATE_SCALE / span
  localparam int RATE_SCALE = 10000;
  localparam int SCALE_W    = $clog2(RATE_SCALE + 1);
  localparam int NUM_W      = CNT_W + SCALE_W;
  localparam int DIVC_W     = $clog2(NUM_W);
  localparam int SAT_W      = (NUM_W > SPEED_W) ? NUM_W : SPEED_W;
  localparam int RATE_MAX   = 131071;
  localparam int MIN_TAPS   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd3;

  localparam logic [MS_W-1:0]    WINDOW_RST = 16'd2000;
  localparam logic [SPEED_W-1:0] ON_RST     = 17'd50;
  localparam logic [SPEED_W-1:0] OFF_RST    = 17'd30;
  localparam logic [MS_W-1:0]    DECAY_RST  = 16'd1000;

  // Command carried in tuser
  localparam logic CMD_TAP  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Output stream word: speed, flag, zero padding
  localparam int OUT_W = 24;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_SCAN,
    OP_PREP,
    OP_DIV,
    OP_FIN,
    OP_POLL,
    OP_EMIT
  } trm_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_POLL,
    COND_SCAN_MORE,
    COND_ZERO_RATE,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } trm_cond_t;

  localparam int STEP_W = 4;

  // Program steps
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISP = 4'd1;
  localparam logic [STEP_W-1:0] STEP_WR   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SCAN = 4'd3;
  localparam logic [STEP_W-1:0] STEP_PREP = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DIV  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_FIN  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_POLL = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_BACK = 4'd9;

  typedef struct packed {
    trm_op_t           op;
    trm_cond_t         cond;
    logic [STEP_W-1:0] target;
  } trm_uword_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic is_poll;
    logic scan_last;
    logic zero_rate;
    logic div_last;
  } trm_status_t;

  // Control store: condition true jumps to target, otherwise falls through
  function automatic trm_uword_t ucode(input logic [STEP_W-1:0] step);
    trm_uword_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: w = '{op: OP_LOAD,  cond: COND_NO_INPUT,  target: STEP_IDLE};
      STEP_DISP: w = '{op: OP_NONE,  cond: COND_IS_POLL,   target: STEP_POLL};
      STEP_WR:   w = '{op: OP_WRITE, cond: COND_NEVER,     target: STEP_IDLE};
      STEP_SCAN: w = '{op: OP_SCAN,  cond: COND_SCAN_MORE, target: STEP_SCAN};
      STEP_PREP: w = '{op: OP_PREP,  cond: COND_ZERO_RATE, target: STEP_EMIT};
      STEP_DIV:  w = '{op: OP_DIV,   cond: COND_DIV_MORE,  target: STEP_DIV};
      STEP_FIN:  w = '{op: OP_FIN,   cond: COND_ALWAYS,    target: STEP_EMIT};
      STEP_POLL: w = '{op: OP_POLL,  cond: COND_NEVER,     target: STEP_IDLE};
      STEP_EMIT: w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,  target: STEP_EMIT};
      STEP_BACK: w = '{op: OP_NONE,  cond: COND_ALWAYS,    target: STEP_IDLE};
      default:   w = '{op: OP_NONE,  cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/trm_sequencer.sv]
module trm_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_busy,
  input  trm_pkg::trm_status_t  status,
  output trm_pkg::trm_op_t      op
);

  logic [trm_pkg::STEP_W-1:0] step;
  logic [trm_pkg::STEP_W-1:0] step_next;
  trm_pkg::trm_uword_t        word;
  logic                       take;

  // Fetch and branch
  always_comb begin
    word = trm_pkg::ucode(step);
    case (word.cond)
      trm_pkg::COND_NEVER:     take = 1'b0;
      trm_pkg::COND_ALWAYS:    take = 1'b1;
      trm_pkg::COND_NO_INPUT:  take = !in_valid;
      trm_pkg::COND_IS_POLL:   take = status.is_poll;
      trm_pkg::COND_SCAN_MORE: take = !status.scan_last;
      trm_pkg::COND_ZERO_RATE: take = status.zero_rate;
      trm_pkg::COND_DIV_MORE:  take = !status.div_last;
      trm_pkg::COND_OUT_BUSY:  take = out_busy;
      default:                 take = 1'b1;
    endcase
    step_next = take ? word.target : step + 1'b1;
    op        = word.op;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= trm_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[design/trm_datapath.sv]
module trm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  trm_pkg::trm_op_t                  op,
  input  logic                              in_take,
  input  logic                              in_command,
  input  logic [trm_pkg::STAMP_W-1:0]       in_now,
  input  logic                              cfg_we,
  input  logic [trm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [trm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output trm_pkg::trm_status_t              status,
  output logic [trm_pkg::SPEED_W-1:0]       speed,
  output logic                              flag
);

  // Configuration
  logic [trm_pkg::MS_W-1:0]    window_ms;
  logic [trm_pkg::SPEED_W-1:0] on_threshold;
  logic [trm_pkg::SPEED_W-1:0] off_threshold;
  logic [trm_pkg::MS_W-1:0]    decay_ms;

  // Request latch
  logic                        command;
  logic [trm_pkg::STAMP_W-1:0] now_ms;

  // Tap ring and walk
  logic [trm_pkg::STAMP_W-1:0] ring [trm_pkg::HISTORY_DEPTH];
  logic [trm_pkg::SLOT_W-1:0]  write_slot;
  logic [trm_pkg::SLOT_W-1:0]  idx;
  logic [trm_pkg::CNT_W-1:0]   count;
  logic [trm_pkg::MS_W-1:0]    span;

  // Divider
  logic [trm_pkg::NUM_W-1:0]   quot;
  logic [trm_pkg::MS_W-1:0]    rem;
  logic [trm_pkg::DIVC_W-1:0]  div_cnt;

  // Hysteresis
  logic [trm_pkg::STAMP_W-1:0] hold_start;

  logic [trm_pkg::STAMP_W-1:0] stamp;
  logic [trm_pkg::STAMP_W-1:0] age;
  logic                        hit;
  logic [trm_pkg::MS_W:0]      rem_sh;
  logic                        ge;
  logic [trm_pkg::NUM_W-1:0]   numer;
  logic [trm_pkg::SPEED_W-1:0] speed_fin;
  logic [trm_pkg::STAMP_W-1:0] held;
  logic                        last_slot;

  always_comb begin
    stamp  = ring[idx];
    age    = now_ms - stamp;
    hit    = (stamp != '0) && (age <= trm_pkg::STAMP_W'(window_ms));
    rem_sh = {rem, quot[trm_pkg::NUM_W-1]};
    ge     = rem_sh >= {1'b0, span};
    numer  = trm_pkg::NUM_W'(count - 1'b1) * trm_pkg::NUM_W'(trm_pkg::RATE_SCALE);
    speed_fin = (trm_pkg::SAT_W'(quot) > trm_pkg::SAT_W'(trm_pkg::RATE_MAX)) ?
                trm_pkg::SPEED_W'(trm_pkg::RATE_MAX) : trm_pkg::SPEED_W'(quot);
    held      = now_ms - hold_start;
    last_slot = write_slot == trm_pkg::SLOT_W'(trm_pkg::HISTORY_DEPTH - 1);

    status.is_poll   = command == trm_pkg::CMD_POLL;
    status.scan_last = idx == trm_pkg::SLOT_W'(trm_pkg::HISTORY_DEPTH - 1);
    status.zero_rate = (count < trm_pkg::CNT_W'(trm_pkg::MIN_TAPS)) || (span == '0);
    status.div_last  = div_cnt == '0;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms     <= trm_pkg::WINDOW_RST;
      on_threshold  <= trm_pkg::ON_RST;
      off_threshold <= trm_pkg::OFF_RST;
      decay_ms      <= trm_pkg::DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        trm_pkg::REG_WINDOW: window_ms     <= cfg_wdata[trm_pkg::MS_W-1:0];
        trm_pkg::REG_ON:     on_threshold  <= cfg_wdata[trm_pkg::SPEED_W-1:0];
        trm_pkg::REG_OFF:    off_threshold <= cfg_wdata[trm_pkg::SPEED_W-1:0];
        trm_pkg::REG_DECAY:  decay_ms      <= cfg_wdata[trm_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Request latch, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      command <= in_command;
      now_ms  <= in_now;
    end
  end

  // Ring store and write pointer; a zero stamp marks an empty slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < trm_pkg::HISTORY_DEPTH; i++) begin
        ring[i] <= '0;
      end
      write_slot <= '0;
    end else if (op == trm_pkg::OP_WRITE) begin
      ring[write_slot] <= now_ms;
      write_slot       <= last_slot ? '0 : write_slot + 1'b1;
    end
  end

  // Walk, divider, result and hysteresis
  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= '0;
      flag       <= 1'b0;
      hold_start <= '0;
    end else begin
      case (op)
        trm_pkg::OP_WRITE: begin
          idx   <= '0;
          count <= '0;
          span  <= '0;
        end
        trm_pkg::OP_SCAN: begin
          idx <= idx + 1'b1;
          if (hit) begin
            count <= count + 1'b1;
            if (age[trm_pkg::MS_W-1:0] > span) begin
              span <= age[trm_pkg::MS_W-1:0];
            end
          end
        end
        trm_pkg::OP_PREP: begin
          quot    <= numer;
          rem     <= '0;
          div_cnt <= trm_pkg::DIVC_W'(trm_pkg::NUM_W - 1);
          if (status.zero_rate) begin
            speed <= '0;
          end
        end
        trm_pkg::OP_DIV: begin
          rem     <= ge ? trm_pkg::MS_W'(rem_sh - {1'b0, span})
                        : rem_sh[trm_pkg::MS_W-1:0];
          quot    <= {quot[trm_pkg::NUM_W-2:0], ge};
          div_cnt <= div_cnt - 1'b1;
        end
        trm_pkg::OP_FIN: begin
          speed <= speed_fin;
        end
        trm_pkg::OP_POLL: begin
          if (speed >= on_threshold) begin
            hold_start <= now_ms;
            flag       <= 1'b1;
          end else if (flag && (speed < off_threshold) &&
                       (held >= trm_pkg::STAMP_W'(decay_ms))) begin
            flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/tap_rate_meter_with_hysteresis.sv]
// Tap: result loaded once the ring walk and the restoring divider have set it; a zero
// rate skips the divider. Poll: result loaded once the hysteresis flag is updated.
// After a load the sequencer passes through STEP_BACK before the next request is taken.
// One request in work at a time; a finished result waits in the output register.
// Synchronous reset clears the ring, pointer, rate, flag, hold timer and sequencer,
// and restores the configuration defaults.
module tap_rate_meter_with_hysteresis (
  input  logic                              clk,
  input  logic                              rst,
  // slave request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [trm_pkg::STAMP_W-1:0]       s_tdata,   // [31:0] now_ms
  input  logic                              s_tuser,   // [0] command
  // master result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [trm_pkg::OUT_W-1:0]         m_tdata,   // [16:0] speed_x10, [17] active_flag
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  trm_pkg::trm_op_t            op;
  trm_pkg::trm_status_t        status;
  logic [trm_pkg::SPEED_W-1:0] speed;
  logic                        flag;
  logic                        out_busy;
  logic                        emit;
  logic                        emit_stall;
  logic                        m_tvalid_next;

  // Handshakes
  always_comb begin
    s_tready      = op == trm_pkg::OP_LOAD;
    cfg_ready     = 1'b1;
    out_busy      = m_tvalid && !m_tready;
    emit          = (op == trm_pkg::OP_EMIT) && !out_busy;
    emit_stall    = (op == trm_pkg::OP_EMIT) && out_busy;
    m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  trm_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .status   (status),
    .op       (op)
  );

  trm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .in_take    (s_tvalid && s_tready),
    .in_command (s_tuser),
    .in_now     (s_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .status     (status),
    .speed      (speed),
    .flag       (flag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= trm_pkg::OUT_W'({flag, speed});
    end
  end

`include "tap_rate_meter_with_hysteresis_assert.svh"

  `TRM_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken twice")
  `TRM_ASSERT_NEXT(a_emit_loads, emit, m_tvalid, "emitted result not presented")
  `TRM_ASSERT_NEXT(a_emit_holds, emit_stall, op == trm_pkg::OP_EMIT, "left emit while busy")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 3000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [trm_pkg::SPEED_W-1:0] speed_x10;
    logic                        active;
  } reading_t;

  // DUT connections, inputs all driven from time zero
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [trm_pkg::STAMP_W-1:0]    s_tdata   = '0;   // [31:0] now_ms
  logic                           s_tuser   = 1'b0; // [0] command
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [trm_pkg::OUT_W-1:0]      m_tdata;          // [16:0] speed_x10, [17] active_flag
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [trm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [trm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  tap_rate_meter_with_hysteresis uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the meter: ring of taps, rate, flag, hold timer and registers
  logic [trm_pkg::STAMP_W-1:0] tap_ring [trm_pkg::HISTORY_DEPTH];
  int unsigned                 write_slot;
  logic [trm_pkg::SPEED_W-1:0] speed_now;
  logic                        flag_now;
  logic [trm_pkg::STAMP_W-1:0] hold_from;
  logic [trm_pkg::MS_W-1:0]    window_ms;
  logic [trm_pkg::SPEED_W-1:0] on_level;
  logic [trm_pkg::SPEED_W-1:0] off_level;
  logic [trm_pkg::MS_W-1:0]    decay_ms;

  reading_t                    pending_readings [$];
  logic                        calm = 1'b0;
  logic [trm_pkg::STAMP_W-1:0] clock_ms = '0;
  int                          mismatches = 0;
  int                          taps_sent = 0;
  int                          polls_sent = 0;
  int                          readings_seen = 0;
  int                          reg_writes = 0;
  int                          settings_run = 0;
  int                          idle_cycles = 0;

  task automatic reset_meter_mirror();
    foreach (tap_ring[i]) tap_ring[i] = '0;
    write_slot = 0;
    speed_now  = '0;
    flag_now   = 1'b0;
    hold_from  = '0;
    window_ms  = trm_pkg::WINDOW_RST;
    on_level   = trm_pkg::ON_RST;
    off_level  = trm_pkg::OFF_RST;
    decay_ms   = trm_pkg::DECAY_RST;
  endtask

  // Rate in tenths per second over the stamps inside the window
  function automatic logic [trm_pkg::SPEED_W-1:0] tap_rate_x10(
    input logic [trm_pkg::STAMP_W-1:0] now);
    int unsigned                 in_window;
    logic [trm_pkg::STAMP_W-1:0] age;
    logic [trm_pkg::STAMP_W-1:0] span;
    longint unsigned             rate;
    in_window = 0;
    span = '0;
    for (int i = 0; i < trm_pkg::HISTORY_DEPTH; i++) begin
      age = now - tap_ring[i];
      // zero stamp marks an empty slot; stamps ahead of now have huge ages
      if (tap_ring[i] != '0 && age <= {16'd0, window_ms}) begin
        in_window++;
        if (age > span) span = age;
      end
    end
    if (in_window < trm_pkg::MIN_TAPS || span == '0) return '0;
    rate = (longint'(in_window - 1) * longint'(trm_pkg::RATE_SCALE)) / longint'(span);
    if (rate > longint'(trm_pkg::RATE_MAX)) rate = longint'(trm_pkg::RATE_MAX);
    return rate[trm_pkg::SPEED_W-1:0];
  endfunction

  task automatic predict_reading(input logic cmd, input logic [trm_pkg::STAMP_W-1:0] now);
    logic [trm_pkg::STAMP_W-1:0] elapsed;
    if (cmd == trm_pkg::CMD_TAP) begin
      tap_ring[write_slot] = now;
      write_slot = (write_slot + 1) % trm_pkg::HISTORY_DEPTH;
      speed_now = tap_rate_x10(now);
    end else begin
      // poll: set at or above on level, clear below off level after decay
      elapsed = now - hold_from;
      if (speed_now >= on_level) begin
        hold_from = now;
        flag_now  = 1'b1;
      end else if (flag_now && speed_now < off_level && elapsed >= {16'd0, decay_ms}) begin
        flag_now = 1'b0;
      end
    end
    pending_readings.push_back('{speed_x10: speed_now, active: flag_now});
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Send one request; valid stays high into the next request unless a gap is drawn
  task automatic send_request(input logic cmd, input logic [trm_pkg::STAMP_W-1:0] now);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= now;
    do @(posedge clk); while (!s_tready);
    predict_reading(cmd, now);
    if (cmd == trm_pkg::CMD_TAP) taps_sent++;
    else polls_sent++;
  endtask

  // Stop the stream and wait for every reading, then let the sequencer settle
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [trm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [trm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      trm_pkg::REG_WINDOW: window_ms = value[trm_pkg::MS_W-1:0];
      trm_pkg::REG_ON:     on_level  = value;
      trm_pkg::REG_OFF:    off_level = value;
      trm_pkg::REG_DECAY:  decay_ms  = value[trm_pkg::MS_W-1:0];
      default:             ;
    endcase
    reg_writes++;
  endtask

  // Program all four registers; the unused top bit of the ms registers is random
  task automatic program_meter(input logic [trm_pkg::MS_W-1:0]    win,
                               input logic [trm_pkg::SPEED_W-1:0] on_lvl,
                               input logic [trm_pkg::SPEED_W-1:0] off_lvl,
                               input logic [trm_pkg::MS_W-1:0]    dec);
    settle();
    write_register(trm_pkg::REG_WINDOW, {1'($urandom_range(0, 1)), win});
    write_register(trm_pkg::REG_ON, on_lvl);
    write_register(trm_pkg::REG_OFF, off_lvl);
    write_register(trm_pkg::REG_DECAY, {1'($urandom_range(0, 1)), dec});
    @(negedge clk) cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Mostly plausible tap and poll sequences on a running clock, plus noise
  task automatic run_tap_traffic(input int count);
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        clock_ms += $urandom_range(0, (window_ms >> 2) + 4);
        send_request(trm_pkg::CMD_TAP, clock_ms);
      end else if (pick < 85) begin
        clock_ms += $urandom_range(0, (decay_ms >> 1) + 4);
        send_request(trm_pkg::CMD_POLL, clock_ms);
      end else if (pick < 90) begin
        // long random jump: stored taps usually fall out of the window
        clock_ms += $urandom;
        send_request(trm_pkg::CMD_TAP, clock_ms);
      end else if (pick < 93) begin
        // land just before the tick wraps
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, window_ms);
        send_request(trm_pkg::CMD_TAP, clock_ms);
      end else if (pick < 95) begin
        send_request(trm_pkg::CMD_TAP, '0);
      end else begin
        send_request(1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  task automatic test_directed();
    // poll on empty state, zero stamp, duplicate stamps, plain rate
    send_request(trm_pkg::CMD_POLL, 32'd0);
    send_request(trm_pkg::CMD_TAP, 32'd0);
    send_request(trm_pkg::CMD_TAP, 32'd100);
    send_request(trm_pkg::CMD_TAP, 32'd100);
    send_request(trm_pkg::CMD_TAP, 32'd300);
    send_request(trm_pkg::CMD_POLL, 32'd300);
    // tap leaves the flag alone; decay not yet passed, then passed
    send_request(trm_pkg::CMD_TAP, 32'd4000);
    send_request(trm_pkg::CMD_POLL, 32'd800);
    send_request(trm_pkg::CMD_POLL, 32'd1300);
    // rate across the tick wrap, then a stamp ahead of the newest tap
    send_request(trm_pkg::CMD_TAP, 32'hFFFF_FF00);
    send_request(trm_pkg::CMD_TAP, 32'hFFFF_FF80);
    send_request(trm_pkg::CMD_TAP, 32'h0000_0040);
    send_request(trm_pkg::CMD_TAP, 32'h0000_0030);
    // full ring with a span of one tick gives the highest rate
    send_request(trm_pkg::CMD_TAP, 32'h7FFF_FFFE);
    repeat (7) send_request(trm_pkg::CMD_TAP, 32'h7FFF_FFFF);
    send_request(trm_pkg::CMD_POLL, 32'hFFFF_FFFF);
    clock_ms = 32'd5000;
  endtask

  task automatic test_default_traffic();
    calm = 1'b1;
    run_tap_traffic(150);
    calm = 1'b0;
    run_tap_traffic(250);
  endtask

  task automatic test_register_sweep();
    program_meter(16'd0, 17'd0, 17'd0, 16'd0);
    run_tap_traffic(125);
    program_meter(16'hFFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
    run_tap_traffic(125);
    program_meter(16'hFFFF, 17'd0, 17'h1FFFF, 16'd0);
    run_tap_traffic(125);
    program_meter(16'd300, 17'd120, 17'd60, 16'd200);
    run_tap_traffic(125);
    program_meter(16'd1000, 17'h1FFFF, 17'd0, 16'd500);
    run_tap_traffic(125);
    program_meter(trm_pkg::MS_W'($urandom_range(200, 4000)),
                  trm_pkg::SPEED_W'($urandom_range(0, 400)),
                  trm_pkg::SPEED_W'($urandom_range(0, 200)),
                  trm_pkg::MS_W'($urandom_range(0, 3000)));
    run_tap_traffic(125);
    program_meter(trm_pkg::MS_W'($urandom), trm_pkg::SPEED_W'($urandom),
                  trm_pkg::SPEED_W'($urandom), trm_pkg::MS_W'($urandom));
    run_tap_traffic(125);
  endtask

  // Result side stalls about a quarter of the time outside calm stretches
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Compare each accepted reading with the oldest prediction
  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending, speed",
                        longint'(m_tdata[trm_pkg::SPEED_W-1:0]), longint'(0));
      end else begin
        want = pending_readings.pop_front();
        if (m_tdata[trm_pkg::SPEED_W-1:0] !== want.speed_x10)
          report_mismatch("speed_x10", longint'(m_tdata[trm_pkg::SPEED_W-1:0]),
                          longint'(want.speed_x10));
        if (m_tdata[trm_pkg::SPEED_W] !== want.active)
          report_mismatch("active_flag", longint'(m_tdata[trm_pkg::SPEED_W]),
                          longint'(want.active));
      end
    end
  end

  // Watchdog on cycles with no request, reading or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    reset_meter_mirror();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed();
    test_default_traffic();
    test_register_sweep();

    settle();
    repeat (40) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch("readings never delivered", longint'(0),
                      longint'(pending_readings.size()));

    $display("Sent %0d taps and %0d polls, checked %0d readings", taps_sent, polls_sent,
             readings_seen);
    $display("Register settings: defaults plus %0d programmed (%0d writes), %0d mismatches",
             settings_run, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
